### rtl/ssaft_pkg.sv
// Package for the smoothstep alpha fade timer: request and register codes,
// datapath widths, controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package ssaft_pkg;

    // Default parameter values
    localparam int TIME_BITS_DEFAULT  = 32;
    localparam int ALPHA_BITS_DEFAULT = 8;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FADE_DURATION = 2'd0;
    localparam logic [1:0] CFG_ALPHA_FULL    = 2'd1;
    localparam logic [1:0] CFG_ALPHA_START   = 2'd2;

    // Configuration reset values
    localparam logic [15:0] DURATION_RESET    = 16'd200;
    localparam logic [7:0]  ALPHA_FULL_RESET  = 8'd255;
    localparam logic [7:0]  ALPHA_START_RESET = 8'd0;

    // Fixed field widths
    localparam int NOW_W   = 32;
    localparam int DUR_W   = 16;
    localparam int LVL_W   = 8;
    localparam int CFG_W   = 16;
    localparam int TERM_W  = DUR_W + 2;          // 3d - 2e
    localparam int SQ_W    = 2 * DUR_W;          // e*e, d*d
    localparam int PROD_W  = SQ_W + TERM_W;      // e*e*(3d-2e)
    localparam int CUBE_W  = 3 * DUR_W;          // d*d*d
    localparam int NUM_W   = PROD_W + LVL_W;     // numerator
    localparam int QBITS   = LVL_W;              // quotient < alpha_full
    localparam int DEN_SH_W = CUBE_W + QBITS - 1;

    typedef struct packed {
        logic load;      // capture the accepted item
        logic eval;      // first multiply stage: e*e, 3d-2e, d*d
        logic mul2;      // e*e*(3d-2e), d*d*d
        logic mul3;      // numerator, divider setup
        logic div_step;  // one quotient bit
        logic commit;    // update state, load result register
    } ssaft_cmd_t;

    typedef struct packed {
        logic need_ease; // tick on a running fade that has not finished
    } ssaft_status_t;

endpackage

### rtl/ssaft_ctrl.sv
// Controller for the smoothstep alpha fade timer: sequences one item through
// the datapath and owns the channel handshakes. Depends on ssaft_pkg.
`timescale 1ns / 1ps

module ssaft_ctrl
    import ssaft_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  ssaft_status_t status,
    output ssaft_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_MUL3 = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam int CNT_W = $clog2(QBITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QBITS - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.need_ease ? S_MUL2 : S_DONE;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/ssaft_dp.sv
// Datapath for the smoothstep alpha fade timer: configuration registers, fade
// state, staged multiplies, restoring divider and result register. Depends on ssaft_pkg.
`timescale 1ns / 1ps

module ssaft_dp
    import ssaft_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEFAULT,
    parameter int ALPHA_BITS = ALPHA_BITS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic [1:0]       req_type,
    input  logic [NOW_W-1:0] now_ms,
    input  ssaft_cmd_t       cmd,
    output ssaft_status_t    status,
    output logic [LVL_W-1:0] alpha,
    output logic             active,
    output logic             changed
);

    // Configuration
    logic [DUR_W-1:0] dur_reg;
    logic [LVL_W-1:0] full_reg;
    logic [LVL_W-1:0] start_lvl_reg;

    // Fade state
    logic [TIME_BITS-1:0]  start_time_reg, start_time_next;
    logic [ALPHA_BITS-1:0] cur_alpha_reg, cur_alpha_next;
    logic                  changed_next;

    // Captured item
    logic [1:0]           req_reg;
    logic [TIME_BITS-1:0] now_reg;

    // Arithmetic pipeline
    logic [SQ_W-1:0]     e2_reg, d2_reg;
    logic [TERM_W-1:0]   term_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [CUBE_W-1:0]   d3_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [DEN_SH_W-1:0] den_sh_reg;
    logic [QBITS-1:0]    q_reg;

    // Output register
    logic [LVL_W-1:0] alpha_reg;
    logic             active_reg, changed_reg;

    logic [TIME_BITS-1:0] elapsed;
    logic                 expired;
    logic [DUR_W-1:0]     e_lo;
    logic [TERM_W-1:0]    term_next;
    logic [NUM_W-1:0]     den_cmp;
    logic                 take_bit;

    assign elapsed = now_reg - start_time_reg;
    assign expired = (elapsed >= TIME_BITS'(dur_reg));
    assign e_lo    = elapsed[DUR_W-1:0];

    assign status.need_ease = (req_reg == REQ_TICK) && (start_time_reg != '0) && !expired;

    assign term_next = TERM_W'({2'b00, dur_reg} + {1'b0, dur_reg, 1'b0})
                     - TERM_W'({1'b0, e_lo, 1'b0});

    assign den_cmp  = NUM_W'(den_sh_reg);
    assign take_bit = (rem_reg >= den_cmp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg       <= DURATION_RESET;
            full_reg      <= ALPHA_FULL_RESET;
            start_lvl_reg <= ALPHA_START_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FADE_DURATION: dur_reg       <= cfg_wdata;
                CFG_ALPHA_FULL:    full_reg      <= cfg_wdata[LVL_W-1:0];
                CFG_ALPHA_START:   start_lvl_reg <= cfg_wdata[LVL_W-1:0];
                default:           ;
            endcase
        end
    end

    // Next fade state for the captured request
    always_comb
    begin
        start_time_next = start_time_reg;
        cur_alpha_next  = cur_alpha_reg;
        changed_next    = 1'b0;
        if (req_reg == REQ_START)
        begin
            start_time_next = now_reg;
            cur_alpha_next  = ALPHA_BITS'(start_lvl_reg);
        end
        else if (req_reg == REQ_RESET)
        begin
            start_time_next = '0;
            cur_alpha_next  = ALPHA_BITS'(full_reg);
        end
        else if (req_reg == REQ_TICK && start_time_reg != '0)
        begin
            changed_next = 1'b1;
            if (expired)
            begin
                start_time_next = '0;
                cur_alpha_next  = ALPHA_BITS'(full_reg);
            end
            else
            begin
                cur_alpha_next = ALPHA_BITS'(q_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            cur_alpha_reg  <= ALPHA_BITS'(ALPHA_FULL_RESET);
        end
        else if (cmd.commit)
        begin
            start_time_reg <= start_time_next;
            cur_alpha_reg  <= cur_alpha_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            now_reg <= TIME_BITS'(now_ms);
        end
        if (cmd.eval)
        begin
            e2_reg   <= SQ_W'(e_lo) * SQ_W'(e_lo);
            d2_reg   <= SQ_W'(dur_reg) * SQ_W'(dur_reg);
            term_reg <= term_next;
        end
        if (cmd.mul2)
        begin
            prod_reg <= PROD_W'(e2_reg) * PROD_W'(term_reg);
            d3_reg   <= CUBE_W'(d2_reg) * CUBE_W'(dur_reg);
        end
        if (cmd.mul3)
        begin
            rem_reg    <= NUM_W'(prod_reg) * NUM_W'(full_reg);
            den_sh_reg <= DEN_SH_W'({d3_reg, {(QBITS-1){1'b0}}});
            q_reg      <= '0;
        end
        if (cmd.div_step)
        begin
            // Restoring step: try the shifted divisor, drop one bit lower each cycle
            if (take_bit)
            begin
                rem_reg <= rem_reg - den_cmp;
            end
            q_reg      <= {q_reg[QBITS-2:0], take_bit};
            den_sh_reg <= den_sh_reg >> 1;
        end
        if (cmd.commit)
        begin
            alpha_reg   <= LVL_W'(cur_alpha_next);
            active_reg  <= (start_time_next != '0);
            changed_reg <= changed_next;
        end
    end

    assign alpha   = alpha_reg;
    assign active  = active_reg;
    assign changed = changed_reg;

endmodule

### rtl/smoothstep_alpha_fade_timer.sv
// Top level of the smoothstep alpha fade timer: joins the controller and the
// datapath. Depends on ssaft_pkg, ssaft_ctrl and ssaft_dp.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready, req_type, now_ms) takes one request item:
//   tick, start fade or reset fade. Output channel (out_valid/out_ready, alpha,
//   active, changed) returns exactly one result item per request, in order.
//   The configuration port (cfg_we, cfg_index, cfg_wdata) writes fade_duration,
//   alpha_full and alpha_start; write it only while no item is in flight.
//   Unknown indexes are ignored.
// Timing
//   One item at a time. A start, reset, idle tick or completing tick passes
//   through the evaluate and done states after acceptance. A tick that eases
//   the level runs three multiply stages and an 8-bit restoring divide (one
//   quotient bit per cycle) before the done state. in_ready rises with
//   out_valid, so no item is taken until the one before it has committed.
// Stall
//   A finished result waits in the output register; the next item is still
//   accepted and computed, then holds in the controller until the output
//   register is taken.
// Reset
//   rst_n clears the fade to idle with its level at 255 and loads the register
//   defaults (duration 200, full 255, start 0); no result is pending.
module smoothstep_alpha_fade_timer
    import ssaft_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEFAULT,
    parameter int ALPHA_BITS = ALPHA_BITS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration write port
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    // request items
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       req_type,
    input  logic [NOW_W-1:0] now_ms,
    // result items
    output logic             out_valid,
    input  logic             out_ready,
    output logic [LVL_W-1:0] alpha,
    output logic             active,
    output logic             changed
);

    ssaft_cmd_t    cmd;
    ssaft_status_t status;

    // Sequence each item: capture, evaluate, optional ease math, commit
    ssaft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold configuration and fade state, compute the eased level
    ssaft_dp #(
        .TIME_BITS  (TIME_BITS),
        .ALPHA_BITS (ALPHA_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_type  (req_type),
        .now_ms    (now_ms),
        .cmd       (cmd),
        .status    (status),
        .alpha     (alpha),
        .active    (active),
        .changed   (changed)
    );

endmodule

### bench/smoothstep_alpha_fade_timer_tb.sv
// Self-checking bench for smoothstep_alpha_fade_timer: a queued request driver,
// a result monitor and an in-bench fade predictor. Also depends on ssaft_pkg.
`timescale 1ns / 1ps

module smoothstep_alpha_fade_timer_tb;
    import ssaft_pkg::*;

    // Codes the package leaves unnamed: the spare request and register index
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASE_COUNT  = 8;
    localparam int SETTLE_TICKS = 20;

    typedef struct packed {
        logic [1:0]       req;
        logic [NOW_W-1:0] now;
    } fade_req_t;

    typedef struct packed {
        logic [LVL_W-1:0] alpha;
        logic             active;
        logic             changed;
    } fade_result_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [1:0]       cfg_index = CFG_FADE_DURATION;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [1:0]       req_type  = REQ_TICK;
    logic [NOW_W-1:0] now_ms    = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [LVL_W-1:0] alpha;
    logic             active;
    logic             changed;

    // Request items waiting for the driver, and results still owed by the block
    fade_req_t    req_queue[$];
    fade_result_t result_queue[$];

    // Shadow copy of the registers and the fade state
    logic [DUR_W-1:0] dur_cfg   = DURATION_RESET;
    logic [LVL_W-1:0] full_cfg  = ALPHA_FULL_RESET;
    logic [LVL_W-1:0] start_cfg = ALPHA_START_RESET;
    logic [NOW_W-1:0] fade_start = '0;
    logic [LVL_W-1:0] fade_level = 8'd255;

    int  issued_cnt   = 0;
    int  accepted_cnt = 0;
    int  received_cnt = 0;
    int  eased_cnt    = 0;
    int  done_cnt     = 0;
    int  err_cnt      = 0;
    int  cycle_cnt    = 0;
    bit  calm         = 1'b0;   // no idling on either side once set

    smoothstep_alpha_fade_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .alpha     (alpha),
        .active    (active),
        .changed   (changed)
    );

    always #5 clk = ~clk;

    // Advance the shadow fade by one request and return the result it owes.
    // The eased level is floor(full * e^2 * (3d - 2e) / d^3), exact in 64 bits.
    function automatic fade_result_t advance_fade(input logic [1:0] req,
                                                  input logic [NOW_W-1:0] now);
        fade_result_t     res;
        logic [NOW_W-1:0] elapsed;
        logic [63:0]      e;
        logic [63:0]      d;
        logic [63:0]      num;
        logic [63:0]      den;
        res.changed = 1'b0;
        if (req == REQ_START) begin
            fade_start = now;
            fade_level = start_cfg;
        end
        else if (req == REQ_RESET) begin
            fade_start = '0;
            fade_level = full_cfg;
        end
        else if (req == REQ_TICK && fade_start != '0) begin
            elapsed = now - fade_start;
            e = {32'd0, elapsed};
            d = {48'd0, dur_cfg};
            if (e >= d) begin
                // completion tick: snap to full and go idle
                fade_level = full_cfg;
                fade_start = '0;
                done_cnt++;
            end
            else begin
                num = e * e * (3 * d - 2 * e) * {56'd0, full_cfg};
                den = d * d * d;
                fade_level = LVL_W'(num / den);
                eased_cnt++;
            end
            res.changed = 1'b1;
        end
        res.alpha  = fade_level;
        res.active = (fade_start != '0);
        return res;
    endfunction

    task automatic push_req(input logic [1:0] req, input logic [NOW_W-1:0] now);
        fade_req_t item;
        item.req = req;
        item.now = now;
        req_queue.push_back(item);
        issued_cnt++;
    endtask

    // Hold the sender until every result owed so far has come back
    task automatic drain();
        wait (received_cnt == issued_cnt);
        repeat (4) @(posedge clk);
    endtask

    // Write one register; only called while nothing is in flight
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FADE_DURATION: dur_cfg   = val;
            CFG_ALPHA_FULL:    full_cfg  = val[LVL_W-1:0];
            CFG_ALPHA_START:   start_cfg = val[LVL_W-1:0];
            default: ;
        endcase
    endtask

    // Pick a register setting; extremes come up often
    task automatic pick_config();
        logic [CFG_W-1:0] dur;
        logic [CFG_W-1:0] full;
        logic [CFG_W-1:0] lvl;
        case ($urandom_range(0, 6))
            0:       dur = 16'hFFFF;
            1:       dur = 16'd1;
            2:       dur = 16'd0;
            3:       dur = CFG_W'($urandom_range(2, 16));
            4:       dur = CFG_W'($urandom_range(100, 1000));
            default: dur = CFG_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       full = 16'h00FF;
            1:       full = 16'h0001;
            default: full = CFG_W'($urandom);   // upper byte must be dropped
        endcase
        case ($urandom_range(0, 4))
            0:       lvl = 16'h0000;
            1:       lvl = 16'h00FF;
            default: lvl = CFG_W'($urandom);
        endcase
        write_reg(CFG_FADE_DURATION, dur);
        write_reg(CFG_ALPHA_FULL, full);
        write_reg(CFG_ALPHA_START, lvl);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_SPARE, CFG_W'($urandom));
    endtask

    // One fade: a start, then ticks that walk across the duration, sometimes broken
    // by a reset, a spare code or a random-time tick; a few sequences are pure noise.
    task automatic push_fade_sequence();
        logic [NOW_W-1:0] t;
        int               n;
        int               step_max;
        if ($urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n)
                push_req(2'($urandom_range(0, 3)), NOW_W'($urandom));
            return;
        end
        case ($urandom_range(0, 7))
            0:       t = 32'hFFFF_FFFF - NOW_W'($urandom_range(0, 2 * dur_cfg + 2));
            1:       t = NOW_W'($urandom_range(0, 3));
            default: t = NOW_W'($urandom);
        endcase
        push_req(REQ_START, t);
        n        = $urandom_range(1, 8);
        step_max = dur_cfg / 4 + 2;
        repeat (n) begin
            case ($urandom_range(0, 11))
                0:       push_req(REQ_RESET, NOW_W'($urandom));
                1:       push_req(REQ_SPARE, NOW_W'($urandom));
                2:       push_req(REQ_TICK, NOW_W'($urandom));
                default:
                begin
                    t = t + NOW_W'($urandom_range(0, step_max));
                    push_req(REQ_TICK, t);
                end
            endcase
        end
    endtask

    // Driver: predict each accepted item, then present the next queued one,
    // with short random gaps between some items until calm is set
    int gap_left = 0;
    always @(posedge clk or negedge rst_n) begin
        fade_req_t item;
        if (!rst_n) begin
            in_valid <= 1'b0;
            req_type <= REQ_TICK;
            now_ms   <= '0;
        end
        else begin
            if (in_valid && in_ready) begin
                result_queue.push_back(advance_fade(req_type, now_ms));
                accepted_cnt++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (req_queue.size() > 0) begin
                    item     = req_queue.pop_front();
                    in_valid <= 1'b1;
                    req_type <= item.req;
                    now_ms   <= item.now;
                    if (!calm && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 4);
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction, and drop
    // out_ready in random bursts
    int stall_left = 0;
    always @(posedge clk or negedge rst_n) begin
        fade_result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                received_cnt++;
                if (result_queue.size() == 0) begin
                    $error("result with no prediction waiting: alpha %0d", alpha);
                    err_cnt++;
                end
                else begin
                    want = result_queue.pop_front();
                    if (alpha !== want.alpha) begin
                        $error("alpha: expected %0d, got %0d", want.alpha, alpha);
                        err_cnt++;
                    end
                    if (active !== want.active) begin
                        $error("active: expected %0d, got %0d", want.active, active);
                        err_cnt++;
                    end
                    if (changed !== want.changed) begin
                        $error("changed: expected %0d, got %0d", want.changed, changed);
                        err_cnt++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                out_ready  <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_cnt, issued_cnt - received_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int ph;
        int phase_end;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset settings (d = 200, full = 255, start = 0)
        push_req(REQ_TICK, 32'd5);            // tick while idle
        push_req(REQ_SPARE, 32'd77);          // spare request code
        push_req(REQ_START, 32'd0);           // start at time zero stays idle
        push_req(REQ_TICK, 32'd10);
        push_req(REQ_START, 32'd1000);
        push_req(REQ_TICK, 32'd1000);         // zero elapsed
        push_req(REQ_TICK, 32'd1100);         // half way
        push_req(REQ_SPARE, 32'd1150);        // spare code mid-fade
        push_req(REQ_TICK, 32'd1199);         // last eased step
        push_req(REQ_TICK, 32'd1200);         // completion
        push_req(REQ_TICK, 32'd1300);
        push_req(REQ_START, 32'hFFFF_FFF0);   // fade across the time wrap
        push_req(REQ_TICK, 32'h0000_0050);
        push_req(REQ_RESET, 32'hFFFF_FFFF);   // reset mid-fade
        push_req(REQ_START, 32'd1);
        push_req(REQ_TICK, 32'hFFFF_FFFF);    // huge elapsed completes
        drain();

        // Widest duration with the narrowest full level
        write_reg(CFG_FADE_DURATION, 16'hFFFF);
        write_reg(CFG_ALPHA_FULL, 16'hFF01);
        write_reg(CFG_ALPHA_START, 16'hFFFF);
        push_req(REQ_START, 32'h8000_0000);
        push_req(REQ_TICK, 32'h8000_FFFE);
        push_req(REQ_TICK, 32'h8001_0000);
        drain();

        // Zero duration completes on the first tick; zero full level
        write_reg(CFG_FADE_DURATION, 16'h0000);
        write_reg(CFG_ALPHA_FULL, 16'h0000);
        write_reg(CFG_SPARE, 16'hFFFF);       // ignored index
        push_req(REQ_START, 32'd42);
        push_req(REQ_TICK, 32'd42);
        push_req(REQ_RESET, 32'd0);
        drain();

        // Random phases, each with its own setting; the last runs with no idling
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            drain();
            pick_config();
            if (ph == PHASE_COUNT - 1)
                calm = 1'b1;
            phase_end = issued_cnt + PHASE_ITEMS;
            while (issued_cnt < phase_end)
                push_fade_sequence();
        end

        wait (accepted_cnt == issued_cnt);
        wait (received_cnt == issued_cnt);
        repeat (SETTLE_TICKS) @(posedge clk);
        if (result_queue.size() != 0) begin
            $error("%0d predicted results never arrived", result_queue.size());
            err_cnt++;
        end

        $display("Ran %0d request items over %0d register settings: %0d eased ticks,",
                 accepted_cnt, PHASE_COUNT + 3, eased_cnt);
        $display("%0d completed fades, %0d results checked, %0d mismatches.",
                 done_cnt, received_cnt, err_cnt);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
